[sv/differential_drive_odometry_core_macros.svh]
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ddo_pkg.sv]
package ddo_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
	localparam int CW = 34;
	localparam int CFG_INDEX_W = 4;
	localparam int STEP_W = 4;

	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] DPT_RESET = 32'd370598;
	localparam logic [31:0] HPD_RESET = 32'd20894414;

	localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_PER_TICK = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEADING_PER_TICK_DIFF = 4'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL,
		ST_DONE
	} ddo_state_t;

	// multiply sequence steps
	typedef enum logic [STEP_W-1:0] {
		STEP_M_LO    = 4'd0,
		STEP_TURN    = 4'd1,
		STEP_XC_HI   = 4'd2,
		STEP_XC_LO   = 4'd3,
		STEP_X_LO    = 4'd4,
		STEP_X_SUM   = 4'd5,
		STEP_X_ADD   = 4'd6,
		STEP_Y_LO    = 4'd7,
		STEP_Y_SUM   = 4'd8,
		STEP_Y_ADD   = 4'd9
	} ddo_step_t;

	typedef struct packed {
		logic done;
		logic flip;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cordic_res_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051D;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517C;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A2F;
			5'd19: v = 32'h00000517;
			5'd20: v = 32'h0000028B;
			5'd21: v = 32'h00000145;
			5'd22: v = 32'h000000A2;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000028;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000002;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

[sv/ddo_counts_if.sv]
interface ddo_counts_if;
	logic valid;
	logic ready;
	logic signed [31:0] right_count;
	logic signed [31:0] left_count;

	modport source (output valid, right_count, left_count, input ready);
	modport sink (input valid, right_count, left_count, output ready);
endinterface

[sv/ddo_pose_if.sv]
interface ddo_pose_if;
	logic valid;
	logic ready;
	logic signed [47:0] x_position;
	logic signed [47:0] y_position;
	logic [31:0] heading;

	modport source (output valid, x_position, y_position, heading, input ready);
	modport sink (input valid, x_position, y_position, heading, output ready);
endinterface

[sv/differential_drive_odometry_core.sv]
// Requests are taken only while idle: a new request waits until the previous one has gone
// through the one-step-per-cycle CORDIC, then six passes through the shared 32x32 multiplier,
// and its result has been moved to the output register.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (arst_n low): pose and previous counters clear to zero, tick scales take their
// default values; no clearing pass is needed.
`include "differential_drive_odometry_core_macros.svh"

module differential_drive_odometry_core import ddo_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_wdata,
	ddo_counts_if.sink             counts,
	ddo_pose_if.source             pose
);

	ddo_state_t state_q, state_d;
	ddo_step_t step_q;

	logic [31:0] dpt_q, hpd_q;
	logic [31:0] prev_r_q, prev_l_q;
	logic [47:0] pose_x_q, pose_y_q;
	logic [31:0] pose_h_q;

	logic [32:0] asum_q;
	logic neg_q;
	logic [31:0] ud_q;
	logic [63:0] m_q;
	logic [31:0] magc_q, mags_q;
	logic negx_q, negy_q;
	logic [47:0] hi_q;
	logic [33:0] lo_q;
	logic [47:0] r_q;

	logic out_valid_q;
	logic [47:0] out_x_q, out_y_q;
	logic [31:0] out_h_q;

	logic accept, load_out, cordic_start;
	logic [31:0] ur, ul;
	logic [32:0] dsum;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic [64:0] lo_sum;
	logic [47:0] r_signed;
	logic signed [CW-1:0] abs_c, abs_s;
	cordic_res_t cres;

	assign accept = counts.valid && counts.ready;
	assign cordic_start = accept;
	assign ur = $unsigned(counts.right_count) - prev_r_q;
	assign ul = $unsigned(counts.left_count) - prev_l_q;
	assign dsum = {ur[31], ur} + {ul[31], ul};
	assign lo_sum = {1'b0, prod_q} + 65'h40000000;
	assign abs_c = cres.x[CW-1] ? -cres.x : cres.x;
	assign abs_s = cres.y[CW-1] ? -cres.y : cres.y;
	assign r_signed = (step_q == STEP_X_ADD ? negx_q : negy_q) ? (48'd0 - r_q) : r_q;

	ddo_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (pose_h_q),
		.res    (cres)
	);

	ddo_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_comb begin
		case (step_q)
			STEP_M_LO: begin
				mul_a = asum_q[31:0];
				mul_b = dpt_q;
			end
			STEP_TURN: begin
				mul_a = ud_q;
				mul_b = hpd_q;
			end
			STEP_XC_HI: begin
				mul_a = m_q[63:32];
				mul_b = magc_q;
			end
			STEP_XC_LO: begin
				mul_a = m_q[31:0];
				mul_b = magc_q;
			end
			STEP_X_SUM: begin
				mul_a = m_q[63:32];
				mul_b = mags_q;
			end
			STEP_X_ADD: begin
				mul_a = m_q[31:0];
				mul_b = mags_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		counts.ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				counts.ready = 1'b1;
				if (counts.valid)
					state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (cres.done)
					state_d = ST_MUL;
			end
			ST_MUL: begin
				if (step_q == STEP_Y_ADD)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || pose.ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_M_LO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL && step_q != STEP_Y_ADD)
				step_q <= ddo_step_t'(step_q + 4'd1);
			else
				step_q <= STEP_M_LO;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (pose.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpt_q <= DPT_RESET;
			hpd_q <= HPD_RESET;
			prev_r_q <= '0;
			prev_l_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DISTANCE_PER_TICK: dpt_q <= cfg_wdata;
					REG_HEADING_PER_TICK_DIFF: hpd_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				prev_r_q <= $unsigned(counts.right_count);
				prev_l_q <= $unsigned(counts.left_count);
			end
			if (state_q == ST_MUL) begin
				case (step_q)
					STEP_XC_HI: pose_h_q <= pose_h_q + prod_q[31:0];
					STEP_X_ADD: pose_x_q <= pose_x_q + r_signed;
					STEP_Y_ADD: pose_y_q <= pose_y_q + r_signed;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= dsum[32];
			asum_q <= dsum[32] ? (33'd0 - dsum) : dsum;
			ud_q <= ur - ul;
		end
		if (state_q == ST_CORDIC && cres.done) begin
			magc_q <= abs_c[31:0];
			mags_q <= abs_s[31:0];
			negx_q <= neg_q ^ cres.x[CW-1] ^ cres.flip;
			negy_q <= neg_q ^ cres.y[CW-1] ^ cres.flip;
		end
		if (state_q == ST_MUL) begin
			case (step_q)
				STEP_TURN: m_q <= prod_q + (asum_q[32] ? {dpt_q, 32'd0} : 64'd0);
				STEP_XC_LO, STEP_X_ADD: hi_q <= {prod_q[46:0], 1'b0};
				STEP_X_LO, STEP_Y_LO: lo_q <= lo_sum[64:31];
				STEP_X_SUM, STEP_Y_SUM: r_q <= hi_q + {14'd0, lo_q};
				default: ;
			endcase
		end
		if (load_out) begin
			out_x_q <= pose_x_q;
			out_y_q <= pose_y_q;
			out_h_q <= pose_h_q;
		end
	end

	assign pose.valid = out_valid_q;
	assign pose.x_position = $signed(out_x_q);
	assign pose.y_position = $signed(out_y_q);
	assign pose.heading = out_h_q;

	`DDO_ASSERT_NEXT(a_accept_starts_cordic, accept, state_q == ST_CORDIC, "request did not start CORDIC")
	`DDO_ASSERT_NOW(a_cordic_done_in_wait, cres.done, state_q == ST_CORDIC, "CORDIC done outside wait")
	`DDO_ASSERT_NEXT(a_mul_end_to_done, state_q == ST_MUL && step_q == STEP_Y_ADD, state_q == ST_DONE, "multiply sequence overran")
	`DDO_ASSERT_NEXT(a_idle_pose_stable, state_q == ST_IDLE, $stable(pose_x_q) && $stable(pose_h_q), "pose changed while idle")

endmodule

[sv/ddo_mul.sv]
module ddo_mul import ddo_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

[sv/ddo_cordic.sv]
module ddo_cordic import ddo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] angle,
	output cordic_res_t res
);

	logic busy_q;
	logic done_q;
	logic [4:0] i_q;
	logic flip_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] z_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] at;
	logic last;
	logic fold;
	logic [31:0] folded;

	assign fold = angle[31] ^ angle[30];
	assign folded = fold ? (angle + 32'h80000000) : angle;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({2'b00, atan_turn(i_q)});
	assign last = (i_q == 5'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (last)
					busy_q <= 1'b0;
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN_Q30;
			y_q <= '0;
			z_q <= $signed({{(CW-32){folded[31]}}, folded});
			flip_q <= fold;
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign res.done = done_q;
	assign res.flip = flip_q;
	assign res.x = x_q;
	assign res.y = y_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

typedef struct {
	logic [47:0] x;
	logic [47:0] y;
	logic [31:0] h;
} pose_t;

class odometry_book;
	localparam longint UNIT_GAIN = 652032874;

	logic [31:0] dist_gain;
	logic [31:0] turn_gain;
	logic [31:0] prev_right;
	logic [31:0] prev_left;
	logic [47:0] pos_x;
	logic [47:0] pos_y;
	logic [31:0] pos_heading;
	logic [31:0] arc_turns [32];
	pose_t pending_poses [$];
	int errors;
	int compared;

	function new();
		dist_gain = 32'd370598;
		turn_gain = 32'd20894414;
		prev_right = '0;
		prev_left = '0;
		pos_x = '0;
		pos_y = '0;
		pos_heading = '0;
		errors = 0;
		compared = 0;
		arc_turns = '{
			32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
			32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
			32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
		};
	endfunction

	function void set_reg(logic [ddo_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
		case (idx)
			ddo_pkg::REG_DISTANCE_PER_TICK: dist_gain = val;
			ddo_pkg::REG_HEADING_PER_TICK_DIFF: turn_gain = val;
			default: ;
		endcase
	endfunction

	// cos/sin of a binary angle, Q30, folded into the right half plane first
	function void rotate(logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, nx;
		logic flip;
		x = UNIT_GAIN;
		y = 0;
		flip = ang[31] ^ ang[30];
		if (flip)
			ang = ang + 32'h8000_0000;
		z = longint'(int'(ang));
		for (int i = 0; i < ddo_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(arc_turns[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(arc_turns[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// travel * c / 2^31, magnitude rounded half up
	function logic [63:0] step_along(logic [63:0] m, logic neg, longint c);
		logic [63:0] mag, r;
		if (c < 0) begin
			neg = !neg;
			mag = -c;
		end else begin
			mag = c;
		end
		r = ((m[63:32] * mag) << 1) + ((64'(m[31:0]) * mag + (64'd1 << 30)) >> 31);
		return neg ? -r : r;
	endfunction

	function void log_counts(logic [31:0] r, logic [31:0] l);
		logic [31:0] ur, ul, turn;
		logic [63:0] span, m;
		longint dsum, c, s;
		logic neg;
		pose_t p;
		ur = r - prev_right;
		ul = l - prev_left;
		dsum = longint'(int'(ur)) + longint'(int'(ul));
		neg = dsum < 0;
		span = neg ? 64'(-dsum) : 64'(dsum);
		m = span * {32'd0, dist_gain};
		rotate(pos_heading, c, s);
		pos_x = pos_x + 48'(step_along(m, neg, c));
		pos_y = pos_y + 48'(step_along(m, neg, s));
		turn = (ur - ul) * turn_gain;
		pos_heading = pos_heading + turn;
		prev_right = r;
		prev_left = l;
		p.x = pos_x;
		p.y = pos_y;
		p.h = pos_heading;
		pending_poses.push_back(p);
	endfunction

	function void compare_field(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	function void check_pose(logic [47:0] x, logic [47:0] y, logic [31:0] h);
		pose_t p;
		if (pending_poses.size() == 0) begin
			errors++;
			$display("%0t: unexpected pose x %h y %h heading %h", $time, x, y, h);
			return;
		end
		p = pending_poses.pop_front();
		compared++;
		compare_field("x_position", p.x, x);
		compare_field("y_position", p.y, y);
		compare_field("heading", 48'(p.h), 48'(h));
	endfunction
endclass

module tb;
	import ddo_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 250;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;

	ddo_counts_if counts_ch ();
	ddo_pose_if pose_ch ();

	differential_drive_odometry_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.counts(counts_ch),
		.pose(pose_ch)
	);

	odometry_book book;
	int sent;
	int poses_seen;
	int quiet;
	int gain_sets;
	bit src_calm;
	bit snk_calm;
	bit hold_req;
	logic [31:0] last_r;
	logic [31:0] last_l;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] corner_count();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic void pick_counts(output logic [31:0] r, output logic [31:0] l);
		int unsigned mode;
		int k;
		mode = $urandom_range(0, 15);
		r = last_r;
		l = last_l;
		if (mode <= 9) begin
			r = last_r + 32'($urandom_range(0, 4000)) - 32'd2000;
			l = last_l + 32'($urandom_range(0, 4000)) - 32'd2000;
		end else if (mode <= 11) begin
			// spin in place
			k = int'($urandom_range(0, 131072)) - 65536;
			r = last_r + k;
			l = last_l - k;
		end else if (mode == 12) begin
			r = last_r + 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
			l = last_l + 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
		end else if (mode == 13) begin
			r = $urandom;
			l = $urandom;
		end else if (mode == 14) begin
			r = corner_count();
			l = corner_count();
		end
	endfunction

	task automatic send_counts(logic [31:0] r, logic [31:0] l);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			counts_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		counts_ch.valid <= 1'b1;
		counts_ch.right_count <= r;
		counts_ch.left_count <= l;
		@(posedge clk);
		while (!counts_ch.ready) @(posedge clk);
		sent++;
		last_r = r;
		last_l = l;
	endtask

	task automatic drain();
		counts_ch.valid <= 1'b0;
		while (poses_seen < sent) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		book.set_reg(idx, val);
	endtask

	task automatic set_gains(logic [31:0] travel, logic [31:0] turn);
		logic [CFG_INDEX_W-1:0] stray;
		stray = REG_HEADING_PER_TICK_DIFF + CFG_INDEX_W'($urandom_range(1, 14));
		write_reg(REG_DISTANCE_PER_TICK, travel);
		write_reg(REG_HEADING_PER_TICK_DIFF, turn);
		write_reg(stray, $urandom);
		cfg_we <= 1'b0;
		gain_sets++;
	endtask

	initial begin : stimulus
		logic [31:0] r, l, travel, turn;
		book = new();
		sent = 0;
		gain_sets = 0;
		src_calm = 1'b0;
		snk_calm = 1'b0;
		hold_req = 1'b0;
		last_r = '0;
		last_l = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_DISTANCE_PER_TICK;
		cfg_wdata <= '0;
		counts_ch.valid <= 1'b0;
		counts_ch.right_count <= '0;
		counts_ch.left_count <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default gains, first sample against zero counters, counter rollover
		send_counts(32'd100, 32'd60);
		send_counts(32'h7FFF_FFFF, 32'h8000_0000);
		send_counts(32'h8000_0000, 32'h7FFF_FFFF);
		send_counts('1, '1);
		send_counts('0, '0);
		send_counts(32'h8000_0010, 32'h7FFF_FFF0);

		// heading to zero, then quarter turns to hit every fold boundary
		drain();
		set_gains(32'h0001_0000, 32'd1);
		send_counts(last_r - book.pos_heading, last_l);
		drain();
		set_gains(32'h0001_0000, 32'h4000_0000);
		repeat (5) send_counts(last_r + 32'd2, last_l + 32'd1);

		// full-scale gains: position and heading wrap
		drain();
		set_gains('1, '1);
		send_counts(last_r + 32'h8000_0000, last_l + 32'h8000_0000);
		send_counts(last_r + 32'h8000_0000, last_l + 32'h8000_0000);
		send_counts(last_r + 32'h7FFF_FFFF, last_l + 32'h8000_0000);
		send_counts(last_r + 32'd5, last_l - 32'd7);

		drain();
		set_gains('0, '0);
		send_counts($urandom, $urandom);
		send_counts($urandom, $urandom);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0, 7: begin
					travel = DPT_RESET;
					turn = HPD_RESET;
				end
				1: begin
					travel = '1;
					turn = '1;
				end
				2: begin
					travel = '0;
					turn = $urandom;
				end
				3: begin
					travel = $urandom;
					turn = '0;
				end
				4: begin
					travel = $urandom_range(1, 1 << 20);
					turn = $urandom_range(1, 1 << 26);
				end
				default: begin
					travel = $urandom;
					turn = $urandom;
				end
			endcase
			set_gains(travel, turn);
			src_calm = (ph % 3 == 1);
			snk_calm = (ph % 4 == 2);
			if (ph == 1)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick_counts(r, l);
				send_counts(r, l);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		$display("odometry run: %0d count samples, %0d poses compared, %0d gain settings",
			sent, book.compared, gain_sets);
		$display("  (zero and full-scale gains, counter rollover, receiver hold-off)");
		if (book.errors == 0 && book.pending_poses.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin : pose_sink
		int gap;
		pose_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = snk_calm ? 0 : $urandom_range(0, 12);
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				pose_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pose_ch.ready <= 1'b1;
			@(posedge clk);
			while (!pose_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (counts_ch.valid && counts_ch.ready)
				book.log_counts(counts_ch.right_count, counts_ch.left_count);
			if (pose_ch.valid && pose_ch.ready) begin
				book.check_pose(pose_ch.x_position, pose_ch.y_position, pose_ch.heading);
				poses_seen++;
			end
			if ((counts_ch.valid && counts_ch.ready) || (pose_ch.valid && pose_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= WATCHDOG_LIMIT) begin
					$display("%0t: watchdog, nothing moved for %0d cycles", $time, quiet);
					$display("tb: errors");
					$finish;
				end
			end
		end
	end

	initial begin
		poses_seen = 0;
		quiet = 0;
	end
endmodule
